// File: hdl/tbcl_pkg.sv
// Shared types, codes and helpers for the text box cursor layout block.
package tbcl_pkg;

    localparam int NUM_BOXES_DEF = 4;

    localparam int COORD_W   = 16;
    localparam int GH_W      = 6;
    localparam int GW_W      = 5;
    localparam int SEL_W     = 2;
    localparam int SCALE_W   = 4;
    localparam int CODE_W    = 8;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int EXT_H_W   = GH_W + SCALE_W;
    localparam int EXT_W_W   = GW_W + SCALE_W;
    localparam int PROD_W    = EXT_W_W + CNT_W;

    localparam logic [OP_W-1:0] OP_CHAR      = 3'd0;
    localparam logic [OP_W-1:0] OP_CLR_ROW   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLR_COL   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR_BOTH  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR_ALL   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESET   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SELECT   = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ORIGIN,
        S_MEASURE,
        S_CHECK,
        S_PLACE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic origin;
        logic measure;
        logic check;
        logic place;
        logic finish;
        logic emit_reset;
        logic emit_skip;
    } t_cmd;

    typedef struct packed {
        logic is_char;
        logic aborted;
        logic skip_now;
        logic out_free;
    } t_sts;

    function automatic logic [SEL_W-1:0] slot_of(input logic [SEL_W-1:0] sel,
                                                 input int unsigned n);
        logic [SEL_W-1:0] v;
        v = sel;
        for (int i = 0; i < 3; i++) begin
            if (32'(v) >= n) begin
                v = v - SEL_W'(n);
            end
        end
        return v;
    endfunction

endpackage

// File: hdl/text_box_cursor_layout_top.sv
// Top level of the text box cursor layout block: controller plus datapath.
// Results issue from a sequencer step: a placed character's from finish, a reset op's from
// origin, a skipped character's from measure, or from place if a string's first character
// does not fit. The six-step sequencer (idle, origin, measure, check, place, finish) takes
// items only in idle; a stalled result holds it in its last step. Synchronous active-low
// reset restores register defaults, clears saved cursors and string state, empties output.
module text_box_cursor_layout_top #(
    parameter int NUM_BOXES = tbcl_pkg::NUM_BOXES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tbcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbcl_pkg::COORD_W-1:0]       i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [tbcl_pkg::OP_W-1:0]          i_op,
    input  logic [tbcl_pkg::CODE_W-1:0]        i_char_code,
    input  logic                               i_first_char,
    input  logic                               i_last_char,
    input  logic [tbcl_pkg::COORD_W-1:0]       i_row_offset,
    input  logic [tbcl_pkg::COORD_W-1:0]       i_col_offset,
    input  logic [tbcl_pkg::SCALE_W-1:0]       i_scale,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [tbcl_pkg::STATUS_W-1:0]      o_status,
    output logic [tbcl_pkg::CODE_W-1:0]        o_char_out,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_row_start,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_row_end,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_col_start,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_col_end,
    output logic                               o_end_of_string
);

    tbcl_pkg::t_cmd cmd;
    tbcl_pkg::t_sts sts;

    tbcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tbcl_dp #(
        .NUM_BOXES (NUM_BOXES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_char_code     (i_char_code),
        .i_first_char    (i_first_char),
        .i_last_char     (i_last_char),
        .i_row_offset    (i_row_offset),
        .i_col_offset    (i_col_offset),
        .i_scale         (i_scale),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_char_out      (o_char_out),
        .o_win_row_start (o_win_row_start),
        .o_win_row_end   (o_win_row_end),
        .o_win_col_start (o_win_col_start),
        .o_win_col_end   (o_win_col_end),
        .o_end_of_string (o_end_of_string),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

// File: hdl/tbcl_ctrl.sv
// Sequencing state machine for the text box cursor layout block.
module tbcl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tbcl_pkg::t_sts    i_sts,
    output tbcl_pkg::t_cmd    o_cmd
);

    tbcl_pkg::t_state r_state;
    tbcl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbcl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tbcl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tbcl_pkg::S_ORIGIN;
            end
            tbcl_pkg::S_ORIGIN: begin
                if (i_sts.is_char) begin
                    n_state = tbcl_pkg::S_MEASURE;
                end else if (i_sts.out_free) begin
                    n_state = tbcl_pkg::S_IDLE;
                end
            end
            tbcl_pkg::S_MEASURE: begin
                if (!i_sts.aborted) begin
                    n_state = tbcl_pkg::S_CHECK;
                end else if (i_sts.out_free) begin
                    n_state = tbcl_pkg::S_IDLE;
                end
            end
            tbcl_pkg::S_CHECK: begin
                n_state = tbcl_pkg::S_PLACE;
            end
            tbcl_pkg::S_PLACE: begin
                if (!i_sts.skip_now) begin
                    n_state = tbcl_pkg::S_FINISH;
                end else if (i_sts.out_free) begin
                    n_state = tbcl_pkg::S_IDLE;
                end
            end
            tbcl_pkg::S_FINISH: begin
                if (i_sts.out_free) n_state = tbcl_pkg::S_IDLE;
            end
            default: begin
                n_state = tbcl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            tbcl_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            tbcl_pkg::S_ORIGIN: begin
                o_cmd.origin     = i_sts.is_char;
                o_cmd.emit_reset = !i_sts.is_char && i_sts.out_free;
            end
            tbcl_pkg::S_MEASURE: begin
                o_cmd.measure   = !i_sts.aborted;
                o_cmd.emit_skip = i_sts.aborted && i_sts.out_free;
            end
            tbcl_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            tbcl_pkg::S_PLACE: begin
                o_cmd.place     = !i_sts.skip_now;
                o_cmd.emit_skip = i_sts.skip_now && i_sts.out_free;
            end
            tbcl_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_reset || o_cmd.emit_skip || o_cmd.finish) |=>
            (r_state == tbcl_pkg::S_IDLE))
        else $error("result issued without return to idle");

    a_load_to_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == tbcl_pkg::S_ORIGIN))
        else $error("accepted item not started");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_reset || o_cmd.emit_skip || o_cmd.finish) |-> i_sts.out_free)
        else $error("result issued into a full output register");

endmodule

// File: hdl/tbcl_dp.sv
// Datapath: configuration, saved cursors, placement arithmetic and output register.
module tbcl_dp #(
    parameter int NUM_BOXES = tbcl_pkg::NUM_BOXES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tbcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbcl_pkg::COORD_W-1:0]       i_cfg_data,
    input  logic [tbcl_pkg::OP_W-1:0]          i_op,
    input  logic [tbcl_pkg::CODE_W-1:0]        i_char_code,
    input  logic                               i_first_char,
    input  logic                               i_last_char,
    input  logic [tbcl_pkg::COORD_W-1:0]       i_row_offset,
    input  logic [tbcl_pkg::COORD_W-1:0]       i_col_offset,
    input  logic [tbcl_pkg::SCALE_W-1:0]       i_scale,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [tbcl_pkg::STATUS_W-1:0]      o_status,
    output logic [tbcl_pkg::CODE_W-1:0]        o_char_out,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_row_start,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_row_end,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_col_start,
    output logic [tbcl_pkg::COORD_W-1:0]       o_win_col_end,
    output logic                               o_end_of_string,
    input  tbcl_pkg::t_cmd                     i_cmd,
    output tbcl_pkg::t_sts                     o_sts
);

    localparam int SLOT_W = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int CW     = tbcl_pkg::COORD_W;

    logic [CW-1:0]                    r_box_top, r_box_bottom, r_box_left, r_box_right;
    logic [tbcl_pkg::GH_W-1:0]        r_glyph_height;
    logic [tbcl_pkg::GW_W-1:0]        r_glyph_width;
    logic [tbcl_pkg::SEL_W-1:0]       r_box_select;

    logic [CW-1:0]                    r_saved_row [NUM_BOXES];
    logic [CW-1:0]                    r_saved_col [NUM_BOXES];
    logic [CW-1:0]                    r_line_row, r_line_col_base, r_origin_row, r_origin_col;
    logic [tbcl_pkg::CNT_W-1:0]       r_chars_in_line;
    logic                             r_placed_any, r_aborted;
    logic [tbcl_pkg::SCALE_W-1:0]     r_latched_scale;

    logic [tbcl_pkg::OP_W-1:0]        r_op;
    logic [tbcl_pkg::CODE_W-1:0]      r_code;
    logic                             r_first, r_last;
    logic [CW-1:0]                    r_row_off, r_col_off;
    logic [tbcl_pkg::SCALE_W-1:0]     r_scale;

    logic [tbcl_pkg::EXT_H_W-1:0]     r_ext_h;
    logic [tbcl_pkg::EXT_W_W-1:0]     r_ext_w;
    logic [CW-1:0]                    r_prod, r_re, r_cs, r_rs_fin, r_cs_fin;
    logic                             r_row_over, r_col_over, r_reh_over;

    logic                             r_out_valid;
    logic [tbcl_pkg::STATUS_W-1:0]    r_status;
    logic [tbcl_pkg::CODE_W-1:0]      r_char_out;
    logic [CW-1:0]                    r_win_rs, r_win_re, r_win_cs, r_win_ce;
    logic                             r_eos;

    logic [SLOT_W-1:0]                slot;
    logic [tbcl_pkg::SCALE_W-1:0]     sc;
    logic [CW-1:0]                    ext_h16, ext_w16;
    logic [tbcl_pkg::PROD_W-1:0]      prod_c;
    logic [CW-1:0]                    cs_c, ce_c, origin_row_c, origin_col_c;
    logic [CW-1:0]                    fin_re, fin_ce;
    logic                             over, wrap_back;
    logic [CW-1:0]                    n_rs, n_base, n_cs;
    logic [tbcl_pkg::CNT_W-1:0]       n_chars;

    assign o_cfg_ready = 1'b1;

    assign slot    = SLOT_W'(tbcl_pkg::slot_of(r_box_select, NUM_BOXES));
    assign sc      = r_first ? r_scale : r_latched_scale;
    assign ext_h16 = CW'(r_ext_h);
    assign ext_w16 = CW'(r_ext_w);
    assign prod_c  = tbcl_pkg::PROD_W'(r_ext_w) * tbcl_pkg::PROD_W'(r_chars_in_line);
    assign cs_c    = r_line_col_base + r_prod;
    assign ce_c    = cs_c + ext_w16;
    assign origin_row_c = r_box_top + r_saved_row[slot] + r_row_off;
    assign origin_col_c = r_box_left + r_saved_col[slot] + r_col_off;
    assign fin_re  = r_rs_fin + ext_h16;
    assign fin_ce  = r_cs_fin + ext_w16;

    always_comb begin
        over      = r_row_over || r_col_over;
        wrap_back = r_col_over ? r_reh_over : r_row_over;
        n_rs      = r_line_row;
        n_base    = r_line_col_base;
        n_cs      = r_cs;
        n_chars   = r_chars_in_line + 1'b1;
        if (over) begin
            n_chars = tbcl_pkg::CNT_W'(1);
            if (wrap_back) begin
                n_rs   = r_origin_row;
                n_base = r_origin_col;
            end else if (r_col_over) begin
                n_rs   = r_re;
                n_base = r_box_left;
            end
            n_cs = n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_top       <= '0;
            r_box_bottom    <= CW'(240);
            r_box_left      <= '0;
            r_box_right     <= CW'(240);
            r_glyph_height  <= tbcl_pkg::GH_W'(16);
            r_glyph_width   <= tbcl_pkg::GW_W'(8);
            r_box_select    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbcl_pkg::CFG_BOX_TOP:      r_box_top      <= i_cfg_data;
                tbcl_pkg::CFG_BOX_BOTTOM:   r_box_bottom   <= i_cfg_data;
                tbcl_pkg::CFG_BOX_LEFT:     r_box_left     <= i_cfg_data;
                tbcl_pkg::CFG_BOX_RIGHT:    r_box_right    <= i_cfg_data;
                tbcl_pkg::CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[tbcl_pkg::GH_W-1:0];
                tbcl_pkg::CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data[tbcl_pkg::GW_W-1:0];
                tbcl_pkg::CFG_BOX_SELECT:   r_box_select   <= i_cfg_data[tbcl_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BOXES; i++) begin
                r_saved_row[i] <= '0;
                r_saved_col[i] <= '0;
            end
            r_line_row      <= '0;
            r_line_col_base <= '0;
            r_origin_row    <= '0;
            r_origin_col    <= '0;
            r_chars_in_line <= '0;
            r_placed_any    <= 1'b0;
            r_aborted       <= 1'b0;
            r_latched_scale <= tbcl_pkg::SCALE_W'(1);
        end else begin
            if (i_cmd.emit_reset) begin
                case (r_op)
                    tbcl_pkg::OP_CLR_ROW: r_saved_row[slot] <= '0;
                    tbcl_pkg::OP_CLR_COL: r_saved_col[slot] <= '0;
                    tbcl_pkg::OP_CLR_BOTH: begin
                        r_saved_row[slot] <= '0;
                        r_saved_col[slot] <= '0;
                    end
                    tbcl_pkg::OP_CLR_ALL: begin
                        for (int i = 0; i < NUM_BOXES; i++) begin
                            r_saved_row[i] <= '0;
                            r_saved_col[i] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.origin && r_first) begin
                r_origin_row    <= origin_row_c;
                r_origin_col    <= origin_col_c;
                r_line_row      <= origin_row_c;
                r_line_col_base <= origin_col_c;
                r_latched_scale <= r_scale;
                r_chars_in_line <= '0;
                r_placed_any    <= 1'b0;
                r_aborted       <= 1'b0;
            end
            if (i_cmd.emit_skip) begin
                r_aborted <= 1'b1;
            end
            if (i_cmd.place) begin
                r_line_row      <= n_rs;
                r_line_col_base <= n_base;
                r_chars_in_line <= n_chars;
                r_placed_any    <= 1'b1;
            end
            if (i_cmd.finish && r_last) begin
                r_saved_row[slot] <= r_rs_fin + ext_h16 - r_box_top;
                r_saved_col[slot] <= r_cs_fin + ext_w16 - r_box_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_code    <= i_char_code;
            r_first   <= i_first_char;
            r_last    <= i_last_char;
            r_row_off <= i_row_offset;
            r_col_off <= i_col_offset;
            r_scale   <= i_scale;
        end
        if (i_cmd.origin) begin
            r_ext_h <= tbcl_pkg::EXT_H_W'(r_glyph_height) * tbcl_pkg::EXT_H_W'(sc);
            r_ext_w <= tbcl_pkg::EXT_W_W'(r_glyph_width) * tbcl_pkg::EXT_W_W'(sc);
        end
        if (i_cmd.measure) begin
            r_prod <= prod_c[CW-1:0];
            r_re   <= r_line_row + ext_h16;
        end
        if (i_cmd.check) begin
            r_cs       <= cs_c;
            r_row_over <= r_re > r_box_bottom;
            r_col_over <= ce_c > r_box_right;
            r_reh_over <= (r_re + ext_h16) > r_box_bottom;
        end
        if (i_cmd.place) begin
            r_rs_fin <= n_rs;
            r_cs_fin <= n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_reset || i_cmd.emit_skip || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_reset || i_cmd.emit_skip) begin
            r_status   <= i_cmd.emit_reset ? tbcl_pkg::ST_RESET : tbcl_pkg::ST_SKIPPED;
            r_char_out <= '0;
            r_win_rs   <= '0;
            r_win_re   <= '0;
            r_win_cs   <= '0;
            r_win_ce   <= '0;
            r_eos      <= i_cmd.emit_skip && r_last;
        end else if (i_cmd.finish) begin
            r_status   <= tbcl_pkg::ST_PLACED;
            r_char_out <= r_code;
            r_win_rs   <= r_rs_fin;
            r_win_re   <= fin_re;
            r_win_cs   <= r_cs_fin;
            r_win_ce   <= fin_ce;
            r_eos      <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_char_out      = r_char_out;
    assign o_win_row_start = r_win_rs;
    assign o_win_row_end   = r_win_re;
    assign o_win_col_start = r_win_cs;
    assign o_win_col_end   = r_win_ce;
    assign o_end_of_string = r_eos;

    assign o_sts.is_char  = (r_op == tbcl_pkg::OP_CHAR);
    assign o_sts.aborted  = r_aborted;
    assign o_sts.skip_now = (r_row_over || r_col_over) && !r_placed_any;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule
